// ===== sv/tspbb_pkg.sv =====
// Package: shared codes, widths, controller states and control structs for the tour search.
`default_nettype none

package tspbb_pkg;

	// configuration register indexes
	localparam logic REG_CITY_COUNT = 1'b0;
	localparam logic REG_COST_BOUND = 1'b1;

	// input word opcodes
	localparam logic OP_ADD_EDGE = 1'b0;
	localparam logic OP_SOLVE    = 1'b1;

	localparam int CITY_COUNT_W = 5;
	localparam int BOUND_W      = 27;
	localparam int EDGE_IN_W    = 16;

	localparam logic [CITY_COUNT_W-1:0] CITY_COUNT_RST = 5'd16;
	localparam logic [BOUND_W-1:0]      COST_BOUND_RST = 27'd100000000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_STEP,
		ST_EVAL_BRANCH,
		ST_EVAL_CLOSE,
		ST_BACK,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_edge;
		logic init;
		logic rd_close;
		logic rd_branch;
		logic skip;
		logic eval_close;
		logic eval_branch;
		logic pop;
		logic finish;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic prune;
		logic at_leaf;
		logic cand_end;
		logic cand_visited;
		logic edge_ok;
		logic depth_zero;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== sv/tspbb_edge_mem.sv =====
// Edge cost memory with per-entry valid flops, one write port and one registered read port.
`default_nettype none

module tspbb_edge_mem #(
	parameter int CITY_W    = 4,
	parameter int COST_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  we,
	input  wire logic [2*CITY_W-1:0]   wr_addr,
	input  wire logic [COST_BITS-1:0]  wr_cost,
	input  wire logic                  clear,
	input  wire logic [2*CITY_W-1:0]   rd_addr,
	output logic      [COST_BITS-1:0]  rd_cost,
	output logic                       rd_valid
);

	localparam int ADDR_W = 2 * CITY_W;
	localparam int DEPTH  = 1 << ADDR_W;

	logic [COST_BITS-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]     valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_cost;
		end
		rd_cost  <= mem_q[rd_addr];
		rd_valid <= valid_q[rd_addr];
	end

	// whole table drops to "no edge" on clear, at the end of a solve
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== sv/tspbb_ctrl.sv =====
// Search controller: sequences edge loads, the depth-first walk and the result word.
`default_nettype none

module tspbb_ctrl
	import tspbb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       opcode,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd,
	output logic            busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (opcode == OP_SOLVE) begin
						state_d = ST_INIT;
					end else begin
						cmd.load_edge = 1'b1;
					end
				end
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = ST_STEP;
			end
			ST_STEP: begin
				priority if (status.prune) begin
					state_d = ST_BACK;
				end else if (status.at_leaf) begin
					cmd.rd_close = 1'b1;
					state_d      = ST_EVAL_CLOSE;
				end else if (status.cand_end) begin
					state_d = ST_BACK;
				end else if (status.cand_visited) begin
					cmd.skip = 1'b1;
				end else begin
					cmd.rd_branch = 1'b1;
					state_d       = ST_EVAL_BRANCH;
				end
			end
			ST_EVAL_BRANCH: begin
				cmd.eval_branch = 1'b1;
				state_d         = ST_STEP;
			end
			ST_EVAL_CLOSE: begin
				cmd.eval_close = 1'b1;
				state_d        = ST_BACK;
			end
			ST_BACK: begin
				if (status.depth_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.pop = 1'b1;
					state_d = ST_STEP;
				end
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/tspbb_datapath.sv =====
// Search datapath: path, candidate and cost stacks, visited flags, best cost and result registers.
`default_nettype none

module tspbb_datapath
	import tspbb_pkg::*;
#(
	parameter int MAX_CITIES = 16,
	parameter int COST_BITS  = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ctrl_cmd_t               cmd,
	output dp_status_t                   status,
	input  wire logic [CITY_COUNT_W-1:0] city_count,
	input  wire logic [BOUND_W-1:0]      cost_bound,
	input  wire logic [CITY_COUNT_W-1:0] from_city,
	input  wire logic [CITY_COUNT_W-1:0] to_city,
	input  wire logic [EDGE_IN_W-1:0]    edge_cost,
	output logic      [BOUND_W-1:0]      best_cost,
	output logic                         tour_found,
	output logic                         done
);

	localparam int CITY_W = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
	localparam int CNT_W  = $clog2(MAX_CITIES + 1);
	localparam int PC_W   = COST_BITS + CNT_W;
	localparam int CMP_W  = (PC_W > BOUND_W) ? PC_W : BOUND_W;

	// search stacks, one entry per depth
	logic [CITY_W-1:0]     path_q  [MAX_CITIES];
	logic [CNT_W-1:0]      cand_q  [MAX_CITIES];
	logic [PC_W-1:0]       pcost_q [MAX_CITIES];
	logic [MAX_CITIES-1:0] visited_q;
	logic [CITY_W-1:0]     depth_q;
	logic [CITY_W-1:0]     tgt_q;
	logic [CNT_W-1:0]      n_q;
	logic [BOUND_W-1:0]    best_q;

	logic [CITY_W-1:0]     cur_city;
	logic [PC_W-1:0]       cur_cost;
	logic [CNT_W-1:0]      cur_cand;
	logic [CITY_W-1:0]     depth_nx;
	logic [PC_W-1:0]       step_cost;
	logic [CMP_W-1:0]      best_cmp;
	logic                  edge_ok;

	logic [COST_BITS-1:0]  rd_cost;
	logic                  rd_valid;
	logic [2*CITY_W-1:0]   rd_addr;
	logic [CITY_W-1:0]     rd_col;
	logic [2*CITY_W-1:0]   wr_addr;
	logic [COST_BITS-1:0]  wr_cost;
	logic [31:0]           cost_ext;
	logic                  wr_ok;
	logic [CNT_W-1:0]      n_eff;
	logic [CITY_COUNT_W-1:0] from_m1;
	logic [CITY_COUNT_W-1:0] to_m1;

	assign cur_city = path_q[depth_q];
	assign cur_cost = pcost_q[depth_q];
	assign cur_cand = cand_q[depth_q];
	assign depth_nx = depth_q + CITY_W'(1);
	assign best_cmp = CMP_W'(best_q);

	// edge from the current city to the candidate (or back to city 1)
	assign step_cost = cur_cost + PC_W'(rd_cost);
	assign edge_ok   = rd_valid && (CMP_W'(step_cost) < best_cmp);

	assign status.prune        = CMP_W'(cur_cost) >= best_cmp;
	assign status.at_leaf      = CNT_W'(depth_q) == (n_q - CNT_W'(1));
	assign status.cand_end     = cur_cand >= n_q;
	assign status.cand_visited = visited_q[cur_cand[CITY_W-1:0]];
	assign status.edge_ok      = edge_ok;
	assign status.depth_zero   = depth_q == '0;

	assign rd_col  = cmd.rd_branch ? cur_cand[CITY_W-1:0] : '0;
	assign rd_addr = {cur_city, rd_col};

	// edge load: cities outside 1..MAX_CITIES are dropped
	assign from_m1  = from_city - CITY_COUNT_W'(1);
	assign to_m1    = to_city - CITY_COUNT_W'(1);
	assign wr_ok    = (from_city != '0) && ({1'b0, from_city} <= (CITY_COUNT_W + 1)'(MAX_CITIES))
		&& (to_city != '0) && ({1'b0, to_city} <= (CITY_COUNT_W + 1)'(MAX_CITIES));
	assign wr_addr  = {from_m1[CITY_W-1:0], to_m1[CITY_W-1:0]};
	assign cost_ext = 32'(edge_cost);
	assign wr_cost  = cost_ext[COST_BITS-1:0];

	// city count clamped into 1..MAX_CITIES
	always_comb begin
		if (city_count == '0) begin
			n_eff = CNT_W'(1);
		end else if ({1'b0, city_count} > (CITY_COUNT_W + 1)'(MAX_CITIES)) begin
			n_eff = CNT_W'(MAX_CITIES);
		end else begin
			n_eff = CNT_W'(city_count);
		end
	end

	tspbb_edge_mem #(
		.CITY_W    (CITY_W),
		.COST_BITS (COST_BITS)
	) u_edge_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (cmd.load_edge && wr_ok),
		.wr_addr  (wr_addr),
		.wr_cost  (wr_cost),
		.clear    (cmd.finish),
		.rd_addr  (rd_addr),
		.rd_cost  (rd_cost),
		.rd_valid (rd_valid)
	);

	// control state of the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= '0;
			visited_q <= '0;
			done      <= 1'b0;
		end else begin
			done <= cmd.finish;
			if (cmd.init) begin
				depth_q   <= '0;
				visited_q <= MAX_CITIES'(1);
			end else if (cmd.eval_branch && edge_ok) begin
				depth_q          <= depth_nx;
				visited_q[tgt_q] <= 1'b1;
			end else if (cmd.pop) begin
				depth_q             <= depth_q - CITY_W'(1);
				visited_q[cur_city] <= 1'b0;
			end
		end
	end

	// stack contents and running best
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			n_q        <= n_eff;
			best_q     <= cost_bound;
			path_q[0]  <= '0;
			pcost_q[0] <= '0;
			cand_q[0]  <= CNT_W'(1);
		end
		if (cmd.skip || cmd.rd_branch) begin
			cand_q[depth_q] <= cur_cand + CNT_W'(1);
		end
		if (cmd.rd_branch) begin
			tgt_q <= cur_cand[CITY_W-1:0];
		end
		if (cmd.eval_branch && edge_ok) begin
			path_q[depth_nx]  <= tgt_q;
			pcost_q[depth_nx] <= step_cost;
			cand_q[depth_nx]  <= CNT_W'(1);
		end
		if (cmd.eval_close && edge_ok) begin
			best_q <= BOUND_W'(step_cost);
		end
		if (cmd.finish) begin
			best_cost  <= best_q;
			tour_found <= best_q < cost_bound;
		end
	end

endmodule

`default_nettype wire

// ===== sv/tsp_branch_bound.sv =====
// Top level: cheapest closed tour search by branch and bound over a loaded edge table.
`default_nettype none

// Cheapest closed tour from city 1 over a directed graph, found by depth-first
// branch and bound. A word is accepted when start is high and busy is low.
// An add-edge word (opcode 0) writes one directed edge as it is accepted; busy
// stays low, so edges load one per cycle back to back. A later edge to the same
// pair overwrites the earlier one; from/to cities of 0 or above MAX_CITIES are
// dropped. A solve word (opcode 1) raises busy for a data-dependent time: a
// setup step, then per candidate city a skip if already on the path or an
// edge table read then an evaluate otherwise, for a full path a read and
// evaluate of the edge back to city 1 then the pop, for any other backtrack
// the step that finds the candidates used up or the path pruned then the pop,
// and a finish step. The walk reads one edge at a time through the single
// read port of the edge table, and the full paths it may visit grow up to
// (n-1)! for n cities. Partial paths whose cost has reached the best so far are
// pruned. When the walk ends, done pulses for exactly one cycle with best_cost
// (cheapest tour below cost_bound, or cost_bound itself) and tour_found; the
// receiver cannot stall it. In the same cycle the edge table drops to
// "no edge" through its valid flops, with no clearing pass, so the next word
// may follow at once. city_count and cost_bound are written through wr_en /
// wr_index / wr_data; the user must do this only while busy is low, the block
// does not enforce it. A city_count of 0 acts as 1; above MAX_CITIES acts as
// MAX_CITIES. With one city the tour is the self edge of city 1.

module tsp_branch_bound
	import tspbb_pkg::*;
#(
	parameter int MAX_CITIES = 16,
	parameter int COST_BITS  = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    opcode,
	input  wire logic [CITY_COUNT_W-1:0] from_city,
	input  wire logic [CITY_COUNT_W-1:0] to_city,
	input  wire logic [EDGE_IN_W-1:0]    edge_cost,
	output logic                         done,
	output logic      [BOUND_W-1:0]      best_cost,
	output logic                         tour_found,
	input  wire logic                    wr_en,
	input  wire logic                    wr_index,
	input  wire logic [BOUND_W-1:0]      wr_data
);

	logic [CITY_COUNT_W-1:0] city_count_q;
	logic [BOUND_W-1:0]      cost_bound_q;
	ctrl_cmd_t               cmd;
	dp_status_t              status;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_count_q <= CITY_COUNT_RST;
			cost_bound_q <= COST_BOUND_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CITY_COUNT: city_count_q <= wr_data[CITY_COUNT_W-1:0];
				REG_COST_BOUND: cost_bound_q <= wr_data;
				default: ;
			endcase
		end
	end

	tspbb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	tspbb_datapath #(
		.MAX_CITIES (MAX_CITIES),
		.COST_BITS  (COST_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.city_count (city_count_q),
		.cost_bound (cost_bound_q),
		.from_city  (from_city),
		.to_city    (to_city),
		.edge_cost  (edge_cost),
		.best_cost  (best_cost),
		.tour_found (tour_found),
		.done       (done)
	);

`ifndef SYNTH
	// a solve word always starts the walk
	a_solve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_SOLVE) |=> busy)
		else $error("solve word did not raise busy");

	// edge loads never stall the next word
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_ADD_EDGE) |=> !busy)
		else $error("edge load raised busy");

	// the result shows while the block is already idle again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while busy");

	// one result word per solve
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
`endif

endmodule

`default_nettype wire

// ===== test/tsp_branch_bound_test.sv =====
// Testbench: self-checking random and directed test of the branch-and-bound tour search.
`default_nettype none

// Edge words load a directed graph into the block, and a solve word asks for the
// cheapest closed tour from city 1. The driver plays out a queue of words that
// the stimulus block fills. It sends in bursts with random gaps. At each accepted
// word it updates its own copy of the edge table. At each accepted solve it runs
// its own search over that copy and queues the expected tour. The monitor checks
// every done strobe against the oldest expected tour. Register writes happen only
// while the block is idle, between phases.
module tsp_branch_bound_test;
	import tspbb_pkg::*;

	localparam int MAX_CITIES = 16;
	localparam int N_WORDS    = 1600;

	typedef struct {
		logic                    op;
		logic [CITY_COUNT_W-1:0] src;
		logic [CITY_COUNT_W-1:0] dst;
		logic [EDGE_IN_W-1:0]    len;
		bit                      wait_idle; // hold until all results are back
	} tsp_word_t;

	typedef struct {
		logic [BOUND_W-1:0] cost;
		logic               found;
	} tour_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    opcode = 1'b0;
	logic [CITY_COUNT_W-1:0] from_city = '0;
	logic [CITY_COUNT_W-1:0] to_city = '0;
	logic [EDGE_IN_W-1:0]    edge_cost = '0;
	logic                    wr_en = 1'b0;
	logic                    wr_index = 1'b0;
	logic [BOUND_W-1:0]      wr_data = '0;
	logic                    busy;
	logic                    done;
	logic [BOUND_W-1:0]      best_cost;
	logic                    tour_found;

	tsp_branch_bound dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.from_city  (from_city),
		.to_city    (to_city),
		.edge_cost  (edge_cost),
		.done       (done),
		.best_cost  (best_cost),
		.tour_found (tour_found),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the block: registers and edge table, 0-based city indexes
	logic [CITY_COUNT_W-1:0] cfg_cities = CITY_COUNT_RST;
	logic [BOUND_W-1:0]      cfg_bound = COST_BOUND_RST;
	logic [MAX_CITIES-1:0]   edge_set [MAX_CITIES];
	logic [EDGE_IN_W-1:0]    edge_len [MAX_CITIES][MAX_CITIES];

	tsp_word_t pending_words [$];
	tour_t     expected_tours [$];
	tsp_word_t cur;

	int errors = 0;
	int words_queued = 0;
	int words_sent = 0;
	int tours_checked = 0;
	int tours_found = 0;
	int settings = 0;
	int gap = 0;
	int burst_left = 1;

	initial begin
		foreach (edge_set[i])
			edge_set[i] = '0;
	end

	// Cheapest closed tour from city 1 whose cost is below the bound, else the bound.
	// Iterative depth-first walk. A partial path is dropped once its cost reaches
	// the best tour so far. Costs are never negative, so the result is exact.
	function automatic logic [BOUND_W-1:0] cheapest_tour();
		int                n;
		int                d;
		int                c;
		int                path [MAX_CITIES];
		int                next_try [MAX_CITIES];
		longint unsigned   path_cost [MAX_CITIES];
		longint unsigned   best;
		longint unsigned   tail;
		logic [MAX_CITIES-1:0] on_path;
		n = int'(cfg_cities);
		if (n < 1)
			n = 1;
		if (n > MAX_CITIES)
			n = MAX_CITIES;
		best = cfg_bound;
		path[0] = 0;
		path_cost[0] = 0;
		next_try[0] = 1;
		on_path = 1;
		d = 0;
		while (d >= 0) begin
			if (d == n - 1) begin
				// every city is on the path: close back to city 1
				if (edge_set[path[d]][0]) begin
					tail = path_cost[d] + edge_len[path[d]][0];
					if (tail < best)
						best = tail;
				end
				if (d > 0)
					on_path[path[d]] = 1'b0;
				d--;
			end else if (next_try[d] >= n) begin
				if (d > 0)
					on_path[path[d]] = 1'b0;
				d--;
			end else begin
				c = next_try[d];
				next_try[d]++;
				if (!on_path[c] && edge_set[path[d]][c] &&
						path_cost[d] + edge_len[path[d]][c] < best) begin
					path_cost[d+1] = path_cost[d] + edge_len[path[d]][c];
					d++;
					path[d] = c;
					next_try[d] = 1;
					on_path[c] = 1'b1;
				end
			end
		end
		return best[BOUND_W-1:0];
	endfunction

	// Driver: a word stays on the ports until taken; bursts of random length,
	// random gaps between them, some bursts back to back.
	always @(posedge clk) begin
		logic  go;
		tour_t res;
		if (arst_n) begin
			go = start;
			if (start && !busy) begin
				words_sent++;
				go = 1'b0;
				if (cur.op == OP_ADD_EDGE) begin
					// cities outside 1..MAX_CITIES are dropped
					if (cur.src >= 1 && cur.src <= MAX_CITIES &&
							cur.dst >= 1 && cur.dst <= MAX_CITIES) begin
						edge_set[cur.src-1][cur.dst-1] = 1'b1;
						edge_len[cur.src-1][cur.dst-1] = cur.len;
					end
				end else begin
					res.cost = cheapest_tour();
					res.found = res.cost < cfg_bound;
					expected_tours.push_back(res);
					foreach (edge_set[i])
						edge_set[i] = '0;
				end
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					burst_left = $urandom_range(1, 24);
				end
			end
			if (!go) begin
				if (gap > 0) begin
					gap--;
				end else if (pending_words.size() > 0 && !(pending_words[0].wait_idle &&
						(expected_tours.size() > 0 || busy))) begin
					cur = pending_words.pop_front();
					go = 1'b1;
					opcode <= cur.op;
					from_city <= cur.src;
					to_city <= cur.dst;
					edge_cost <= cur.len;
				end
			end
			start <= go;
		end
	end

	// Monitor: done cannot be held off, so every strobe is checked as it comes.
	always @(posedge clk) begin
		tour_t want;
		if (arst_n && done) begin
			if (expected_tours.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, best_cost %0d tour_found %0b", $time,
					best_cost, tour_found);
			end else begin
				want = expected_tours.pop_front();
				tours_checked++;
				if (want.found)
					tours_found++;
				if (best_cost !== want.cost) begin
					errors++;
					$display("%0t: best_cost expected %0d got %0d", $time, want.cost,
						best_cost);
				end
				if (tour_found !== want.found) begin
					errors++;
					$display("%0t: tour_found expected %0b got %0b", $time, want.found,
						tour_found);
				end
			end
		end
	end

	task automatic queue_word(input logic op, input int src, input int dst, input int len,
			input bit hold);
		tsp_word_t w;
		w.op = op;
		w.src = src[CITY_COUNT_W-1:0];
		w.dst = dst[CITY_COUNT_W-1:0];
		w.len = len[EDGE_IN_W-1:0];
		w.wait_idle = hold;
		pending_words.push_back(w);
		words_queued++;
	endtask

	// register write; the shadow copy is updated as the write is driven, before the block captures it
	task automatic write_reg(input logic idx, input logic [BOUND_W-1:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		if (idx == REG_CITY_COUNT)
			cfg_cities = data[CITY_COUNT_W-1:0];
		else
			cfg_bound = data;
		settings++;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// wait until every queued word is accepted and every result is back, then let
	// any edge write that is still landing finish
	task automatic settle();
		while (words_sent < words_queued || busy || expected_tours.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int                 cities;
		int                 n;
		int                 r;
		int                 groups;
		int                 cmax;
		int                 j;
		int                 tmp;
		int                 bad;
		int                 order [MAX_CITIES];
		logic [31:0]        rnd;
		logic [BOUND_W-1:0] bound;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// reset settings, empty table: no tour over sixteen cities
		queue_word(OP_SOLVE, 0, 0, 0, 0);
		settle();

		// single city: the self edge of city 1 is the tour; bad cities dropped
		write_reg(REG_CITY_COUNT, 1);
		queue_word(OP_ADD_EDGE, 1, 1, 16'hFFFF, 0);
		queue_word(OP_ADD_EDGE, 0, 1, 5, 0);
		queue_word(OP_ADD_EDGE, 1, 0, 5, 0);
		queue_word(OP_ADD_EDGE, 17, 1, 5, 0);
		queue_word(OP_ADD_EDGE, 31, 31, 0, 0);
		queue_word(OP_ADD_EDGE, 16, 16, 0, 0); // unused city
		queue_word(OP_SOLVE, 31, 31, 16'hFFFF, 0);
		// table was cleared by the solve
		queue_word(OP_SOLVE, 0, 0, 0, 1);
		settle();

		// two cities, widest bound, overwrite of 1->2, edges to unused cities
		write_reg(REG_CITY_COUNT, 2);
		write_reg(REG_COST_BOUND, '1);
		queue_word(OP_ADD_EDGE, 1, 2, 7, 0);
		queue_word(OP_ADD_EDGE, 2, 1, 0, 0);
		queue_word(OP_ADD_EDGE, 1, 2, 5, 0);
		queue_word(OP_ADD_EDGE, 3, 1, 0, 0);
		queue_word(OP_ADD_EDGE, 1, 16, 0, 0);
		queue_word(OP_SOLVE, 0, 0, 0, 0);
		settle();

		// zero bound: nothing qualifies, not even a free tour
		write_reg(REG_COST_BOUND, 0);
		queue_word(OP_ADD_EDGE, 1, 2, 0, 0);
		queue_word(OP_ADD_EDGE, 2, 1, 0, 0);
		queue_word(OP_SOLVE, 0, 0, 0, 0);
		settle();

		// city count 0 acts as 1; bound 1 admits cost 0 only
		write_reg(REG_CITY_COUNT, 0);
		write_reg(REG_COST_BOUND, 1);
		queue_word(OP_ADD_EDGE, 1, 1, 0, 0);
		queue_word(OP_SOLVE, 0, 0, 0, 0);
		queue_word(OP_ADD_EDGE, 1, 1, 1, 0);
		queue_word(OP_SOLVE, 0, 0, 0, 0);

		// --- random part: phases of register settings, each with several graphs ---
		while (words_queued < N_WORDS) begin
			settle();
			r = $urandom_range(0, 19);
			if (r == 0)
				cities = 0;
			else if (r == 1)
				cities = 1;
			else if (r < 16)
				cities = $urandom_range(2, 6);
			else if (r < 18)
				cities = $urandom_range(7, 15);
			else if (r == 18)
				cities = 16;
			else
				cities = $urandom_range(17, 31);
			// upper data bits are outside the register and must not matter
			rnd = $urandom;
			write_reg(REG_CITY_COUNT, ($urandom_range(0, 3) == 0) ?
				{rnd[21:0], cities[4:0]} : BOUND_W'(cities));
			r = $urandom_range(0, 19);
			if (r == 0)
				bound = '0;
			else if (r == 1)
				bound = 1;
			else if (r == 2)
				bound = '1;
			else if (r < 7)
				bound = $urandom_range(1, 300000);
			else if (r < 9)
				bound = BOUND_W'($urandom);
			else
				bound = COST_BOUND_RST;
			write_reg(REG_COST_BOUND, bound);

			n = (cities < 1) ? 1 : (cities > MAX_CITIES) ? MAX_CITIES : cities;
			groups = $urandom_range(2, 8);
			for (int g = 0; g < groups; g++) begin
				cmax = ($urandom_range(0, 1) == 0) ? 15 : 65535; // small costs force ties
				if ($urandom_range(0, 19) == 0) begin
					// solve on an empty table
				end else if (n <= 6) begin
					// dense graph: the search stays short for few cities
					for (int f = 1; f <= n; f++) begin
						for (int t = 1; t <= n; t++) begin
							if ((f != t || n == 1 || $urandom_range(0, 9) == 0) &&
									$urandom_range(0, 4) != 0) begin
								queue_word(OP_ADD_EDGE, f, t, $urandom_range(0, cmax), 0);
								if ($urandom_range(0, 9) == 0)
									queue_word(OP_ADD_EDGE, f, t, $urandom_range(0, cmax), 0);
							end
						end
					end
				end else begin
					// many cities: a ring through a shuffled order, a few links
					// missing, plus a few stray edges, so the search stays small
					order[0] = 1;
					for (int i = 1; i < n; i++)
						order[i] = i + 1;
					for (int i = n - 1; i >= 2; i--) begin
						j = $urandom_range(1, i);
						tmp = order[i];
						order[i] = order[j];
						order[j] = tmp;
					end
					for (int i = 0; i < n; i++)
						if ($urandom_range(0, 9) != 0)
							queue_word(OP_ADD_EDGE, order[i], order[(i+1) % n],
								$urandom_range(0, cmax), 0);
					r = $urandom_range(0, 3);
					for (int k = 0; k < r; k++)
						queue_word(OP_ADD_EDGE, $urandom_range(1, n), $urandom_range(1, n),
							$urandom_range(0, cmax), 0);
				end
				// noise: bad cities and cities above the count in use
				r = $urandom_range(0, 2);
				for (int k = 0; k < r; k++) begin
					bad = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
					case ($urandom_range(0, 2))
						0: queue_word(OP_ADD_EDGE, bad, $urandom_range(0, 31), $urandom, 0);
						1: queue_word(OP_ADD_EDGE, $urandom_range(0, 31), bad, $urandom, 0);
						default: begin
							if (n < MAX_CITIES)
								queue_word(OP_ADD_EDGE, $urandom_range(n + 1, MAX_CITIES),
									$urandom_range(1, MAX_CITIES), $urandom, 0);
						end
					endcase
				end
				queue_word(OP_SOLVE, $urandom, $urandom, $urandom, $urandom_range(0, 7) == 0);
			end
		end

		settle();
		repeat (16) @(posedge clk);
		$display("%0d words accepted over %0d register writes", words_sent, settings);
		$display("%0d solve results checked, %0d with a tour below the bound",
			tours_checked, tours_found);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog, far above the slowest expected run
	initial begin
		#50000000;
		$display("timeout with %0d results outstanding", expected_tours.size());
		$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/tspbb_pkg.sv
sv/tspbb_edge_mem.sv
sv/tspbb_ctrl.sv
sv/tspbb_datapath.sv
sv/tsp_branch_bound.sv
test/tsp_branch_bound_test.sv
